// ----- rtl/mvm_pkg.sv -----
// Shared constants and types for the fixed-point matrix-vector multiplier.
`timescale 1ns / 1ps

package mvm_pkg;

  localparam int MAX_COLUMNS = 1024;
  localparam int COL_W       = $clog2(MAX_COLUMNS);
  localparam int LEN_W       = COL_W + 1;

  localparam int VALUE_W    = 16;
  localparam int PROD_W     = 2 * VALUE_W;
  localparam int ACC_W      = 48;
  localparam int FRAC_W     = 12;
  localparam int SHIFT_W    = ACC_W - FRAC_W;
  localparam int SUM_W      = 32;
  localparam int ROW_W      = 16;
  localparam int RLEN_CFG_W = 11;
  localparam int RCNT_CFG_W = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT  = CFG_IDX_W'(1);

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_MATRIX = 1'b1;

  // Row bookkeeping carried alongside a matrix element down the pipeline
  typedef struct packed {
    logic             end_row;
    logic             last;
    logic [ROW_W-1:0] row;
  } row_tag_t;

endpackage

// ----- rtl/mvm_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module mvm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/matrix_vector_multiply.sv -----
// Top level of the streaming fixed-point matrix-vector multiplier.
//
// Load the vector with tuser 0 transactions (one Q3.12 entry each), then stream
// the matrix row-major with tuser 1; one saturated Q19.12 row sum leaves per row,
// with tlast on the final row of the product. The block takes one transaction
// per cycle while not stalled, loads and matrix elements alike: the vector entry
// for the element's column is read from the single-port-read RAM in the cycle the
// element is accepted, the 16x16 product is registered, and the 48-bit accumulator
// then adds it, so a row sum passes the element and product registers first.
// The input stalls only while a finished row sum is ready to move into the output
// register and the previous one has not yet been taken.
`timescale 1ns / 1ps

module matrix_vector_multiply (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [15:0]                     s_axis_tdata,  // value[15:0]
  input  logic                            s_axis_tuser,  // func[0]
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [47:0]                     m_axis_tdata,  // row_sum[31:0], row_index[47:32]
  output logic                            m_axis_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mvm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mvm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import mvm_pkg::*;

  // configuration
  logic [RLEN_CFG_W-1:0] row_length;
  logic [RCNT_CFG_W-1:0] row_count;
  logic [LEN_W-1:0]      eff_len;
  logic [ROW_W-1:0]      eff_count;

  // control state
  logic [COL_W-1:0] load_pointer;
  logic [COL_W-1:0] column_position;
  logic [ROW_W-1:0] row_position;
  logic signed [ACC_W-1:0] accumulator;

  // pipeline
  logic                      adv;
  logic                      accept;
  logic                      load_acc;
  logic                      mat_acc;
  logic                      end_row_now;
  logic                      last_now;
  logic [LEN_W-1:0]          col_inc;
  logic [LEN_W-1:0]          ptr_inc;
  logic [ROW_W:0]            row_inc;

  logic                      s1_valid;
  logic signed [VALUE_W-1:0] s1_value;
  row_tag_t                  s1_tag;
  logic signed [VALUE_W-1:0] vec_rdata;

  logic                      s2_valid;
  logic signed [PROD_W-1:0]  s2_prod;
  row_tag_t                  s2_tag;

  logic signed [ACC_W-1:0]   acc_sum;
  logic signed [SHIFT_W-1:0] shifted;
  logic [SUM_W-1:0]          sat_sum;
  logic                      overflow;

  logic                      out_valid;
  logic [SUM_W-1:0]          out_sum;
  logic [ROW_W-1:0]          out_row;
  logic                      out_last;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_length <= RLEN_CFG_W'(1);
      row_count  <= RCNT_CFG_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ROW_LENGTH: row_length <= cfg_data[RLEN_CFG_W-1:0];
        REG_ROW_COUNT:  row_count  <= cfg_data[RCNT_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (row_length == '0) begin
      eff_len = LEN_W'(1);
    end else if (32'(row_length) > MAX_COLUMNS) begin
      eff_len = LEN_W'(MAX_COLUMNS);
    end else begin
      eff_len = LEN_W'(row_length);
    end
    eff_count = (row_count == '0) ? ROW_W'(1) : ROW_W'(row_count);
  end

  // hold everything while a row sum cannot move into a full output register
  assign adv      = !(s2_valid && s2_tag.end_row && out_valid && !m_axis_tready);
  assign s_axis_tready = adv;
  assign accept   = s_axis_tvalid && adv;
  assign load_acc = accept && (s_axis_tuser == FUNC_LOAD);
  assign mat_acc  = accept && (s_axis_tuser == FUNC_MATRIX);

  assign col_inc     = {1'b0, column_position} + LEN_W'(1);
  assign ptr_inc     = {1'b0, load_pointer} + LEN_W'(1);
  assign row_inc     = {1'b0, row_position} + (ROW_W + 1)'(1);
  assign end_row_now = (col_inc >= eff_len);
  assign last_now    = (row_inc >= {1'b0, eff_count});

  always_ff @(posedge clk) begin
    if (rst) begin
      load_pointer    <= '0;
      column_position <= '0;
      row_position    <= '0;
    end else begin
      if (load_acc) begin
        load_pointer <= (ptr_inc >= eff_len) ? '0 : ptr_inc[COL_W-1:0];
      end
      if (mat_acc) begin
        if (end_row_now) begin
          column_position <= '0;
          row_position    <= last_now ? '0 : row_inc[ROW_W-1:0];
        end else begin
          column_position <= col_inc[COL_W-1:0];
        end
      end
    end
  end

  mvm_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (MAX_COLUMNS)
  ) u_vector_ram (
    .clk   (clk),
    .we    (load_acc),
    .waddr (load_pointer),
    .wdata (s_axis_tdata),
    .re    (adv),
    .raddr (column_position),
    .rdata (vec_rdata)
  );

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= mat_acc;
      s2_valid <= s1_valid;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_value       <= s_axis_tdata;
      s1_tag.end_row <= end_row_now;
      s1_tag.last    <= last_now;
      s1_tag.row     <= row_position;
      s2_prod        <= s1_value * vec_rdata;
      s2_tag         <= s1_tag;
    end
  end

  assign acc_sum  = accumulator + {{(ACC_W - PROD_W){s2_prod[PROD_W-1]}}, s2_prod};
  assign shifted  = acc_sum[ACC_W-1:FRAC_W];
  // the shifted sum fits when every bit above the result sign matches it
  assign overflow = (shifted[SHIFT_W-1:SUM_W-1] != '0) && (shifted[SHIFT_W-1:SUM_W-1] != '1);
  always_comb begin
    if (overflow) begin
      sat_sum = shifted[SHIFT_W-1] ? {1'b1, {(SUM_W - 1){1'b0}}} : {1'b0, {(SUM_W - 1){1'b1}}};
    end else begin
      sat_sum = shifted[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (adv && s2_valid) begin
        accumulator <= s2_tag.end_row ? '0 : acc_sum;
      end
      if (adv && s2_valid && s2_tag.end_row) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid && s2_tag.end_row) begin
      out_sum  <= sat_sum;
      out_row  <= s2_tag.row;
      out_last <= s2_tag.last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_row, out_sum};
  assign m_axis_tlast  = out_last;

  // input stalls only behind a row sum blocked by a full output register
  assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (s2_valid && s2_tag.end_row && out_valid))
    else $error("input stalled without a blocked row result");

  // accumulator restarts after every finished row
  assert property (@(posedge clk) disable iff (rst)
    (adv && s2_valid && s2_tag.end_row) |=> (accumulator == '0))
    else $error("accumulator not cleared at end of row");

  // a result appears only when a row ends in the accumulate stage
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s2_valid && s2_tag.end_row && adv))
    else $error("result raised without a finished row");

endmodule

// ----- test/mvm_row_checker.sv -----
// Channel monitor for the matrix-vector multiplier: predicts every row sum and compares.
`timescale 1ns / 1ps

module mvm_row_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [15:0]                    s_axis_tdata,  // value[15:0]
  input  logic                           s_axis_tuser,  // func[0]
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [47:0]                    m_axis_tdata,  // row_sum[31:0], row_index[47:32]
  input  logic                           m_axis_tlast,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [mvm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mvm_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             pending,
  output int                             rows_checked
);
  import mvm_pkg::*;

  localparam longint SUM_CEIL  = 64'sd2147483647;
  localparam longint SUM_FLOOR = -64'sd2147483648;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [ROW_W-1:0]        row;
    logic                    last;
  } row_sum_t;

  logic signed [VALUE_W-1:0] coeff_ram [MAX_COLUMNS];
  logic [COL_W-1:0]          wr_slot;
  logic [COL_W-1:0]          col_idx;
  logic [ROW_W-1:0]          row_idx;
  logic signed [ACC_W-1:0]   dot_acc;
  logic [RLEN_CFG_W-1:0]     cols_cfg;
  logic [RCNT_CFG_W-1:0]     rows_cfg;
  row_sum_t                  owed_sums [$];

  function automatic int cols_in_row();
    if (cols_cfg == '0) return 1;
    if (cols_cfg > MAX_COLUMNS) return MAX_COLUMNS;
    return int'(cols_cfg);
  endfunction

  function automatic int rows_in_product();
    return (rows_cfg == '0) ? 1 : int'(rows_cfg);
  endfunction

  task automatic predict_item(input logic func, input logic signed [VALUE_W-1:0] v);
    int                      span;
    logic signed [PROD_W-1:0] prod;
    longint                  scaled;
    row_sum_t                done;
    span = cols_in_row();
    if (func == FUNC_LOAD) begin
      coeff_ram[wr_slot] = v;
      wr_slot = (int'(wr_slot) + 1 >= span) ? '0 : wr_slot + 1'b1;
    end else begin
      prod    = v * coeff_ram[col_idx];
      dot_acc = dot_acc + prod;
      if (int'(col_idx) + 1 < span) begin
        col_idx = col_idx + 1'b1;
      end else begin
        // arithmetic shift floors toward minus infinity
        scaled = longint'(dot_acc >>> FRAC_W);
        if (scaled > SUM_CEIL) scaled = SUM_CEIL;
        else if (scaled < SUM_FLOOR) scaled = SUM_FLOOR;
        done.sum  = scaled[SUM_W-1:0];
        done.row  = row_idx;
        done.last = (int'(row_idx) + 1 >= rows_in_product());
        owed_sums.push_back(done);
        row_idx = done.last ? '0 : row_idx + 1'b1;
        col_idx = '0;
        dot_acc = '0;
      end
    end
  endtask

  task automatic compare_sum();
    row_sum_t want;
    if (owed_sums.size() == 0) begin
      fail_count++;
      $display("%0t: row sum %0d for row %0d arrived with none outstanding", $time,
               $signed(m_axis_tdata[SUM_W-1:0]), m_axis_tdata[SUM_W+ROW_W-1:SUM_W]);
    end else begin
      want = owed_sums.pop_front();
      rows_checked++;
      if (m_axis_tdata[SUM_W-1:0] !== want.sum) begin
        fail_count++;
        $display("%0t: row_sum expected %0d, actual %0d", $time, want.sum,
                 $signed(m_axis_tdata[SUM_W-1:0]));
      end
      if (m_axis_tdata[SUM_W+ROW_W-1:SUM_W] !== want.row) begin
        fail_count++;
        $display("%0t: row_index expected %0d, actual %0d", $time, want.row,
                 m_axis_tdata[SUM_W+ROW_W-1:SUM_W]);
      end
      if (m_axis_tlast !== want.last) begin
        fail_count++;
        $display("%0t: last_row expected %0b, actual %0b", $time, want.last, m_axis_tlast);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      wr_slot  = '0;
      col_idx  = '0;
      row_idx  = '0;
      dot_acc  = '0;
      cols_cfg = RLEN_CFG_W'(1);
      rows_cfg = RCNT_CFG_W'(1);
      owed_sums.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) compare_sum();
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROW_LENGTH: cols_cfg = cfg_data[RLEN_CFG_W-1:0];
          REG_ROW_COUNT:  rows_cfg = cfg_data[RCNT_CFG_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) predict_item(s_axis_tuser, s_axis_tdata);
    end
    pending = owed_sums.size();
  end

endmodule

// ----- test/matrix_vector_multiply_tb.sv -----
// Stimulus, pacing and verdict for the matrix-vector multiplier regression.
`timescale 1ns / 1ps

module matrix_vector_multiply_tb;
  import mvm_pkg::*;

  localparam int RANDOM_ITEMS  = 1800;
  localparam int TAIL_ITEMS    = 300;
  localparam int QUIET_LIMIT   = 5000;
  localparam int SINK_HOLD     = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 16;
  localparam int HOLD_SHAPE    = 3;

  logic                  clk;
  logic                  rst           = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [15:0]           s_axis_tdata  = '0;
  logic                  s_axis_tuser  = FUNC_LOAD;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [47:0]           m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  cfg_valid     = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index     = REG_ROW_LENGTH;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;

  int fail_count;
  int pending;
  int rows_checked;

  bit pace_src  = 1'b1;
  bit pace_sink = 1'b1;
  bit hold_sink = 1'b0;

  // shadow of the load pointer and effective row length, so vectors are fully loaded
  int load_slot = 0;
  int span      = 1;
  int n_loads   = 0;
  int n_elems   = 0;
  int n_shapes  = 0;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  matrix_vector_multiply u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  mvm_row_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending),
    .rows_checked  (rows_checked)
  );

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // output side: one long hold on request, otherwise random stall bursts
  initial begin : sink_pacing
    forever begin
      @(negedge clk);
      if (hold_sink) begin
        m_axis_tready <= 1'b0;
        repeat (SINK_HOLD) @(negedge clk);
        hold_sink = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (pace_sink && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] encode_len(input int cols);
    logic [CFG_DATA_W-1:0] word;
    word = CFG_DATA_W'(cols);
    if (cols == 1 && $urandom_range(0, 2) == 0)
      word = '0;
    else if ($urandom_range(0, 3) == 0)
      word = word | (CFG_DATA_W'($urandom) << RLEN_CFG_W);  // junk above the field
    return word;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] encode_count(input int rows);
    if (rows == 1 && $urandom_range(0, 2) == 0) return '0;
    return CFG_DATA_W'(rows);
  endfunction

  task automatic offer_item(input logic func, input logic [15:0] v);
    @(negedge clk);
    if (pace_src && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    s_axis_tuser  <= func;
    do @(posedge clk); while (!s_axis_tready);
    if (func == FUNC_LOAD) begin
      load_slot = (load_slot + 1 >= span) ? 0 : load_slot + 1;
      n_loads++;
    end else begin
      n_elems++;
    end
  endtask

  // registers change only once every owed row sum is out and the pipeline has settled
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_ROW_LENGTH) begin
      span = int'(data[RLEN_CFG_W-1:0]);
      if (span == 0) span = 1;
      else if (span > MAX_COLUMNS) span = MAX_COLUMNS;
    end
  endtask

  // cover every slot below the row length, whichever slot the pointer sits on
  task automatic load_vector();
    int need;
    need = (load_slot < span) ? span : span + 1;
    repeat (need) offer_item(FUNC_LOAD, pick_value());
  endtask

  task automatic stream_elems(input int n, input bit noisy);
    for (int i = 0; i < n; i++) begin
      if (noisy && $urandom_range(0, 24) == 0) offer_item(FUNC_LOAD, pick_value());
      offer_item(FUNC_MATRIX, pick_value());
    end
  endtask

  initial begin : stimulus
    int rand_items;
    int start;
    int style;
    int pick;
    int cols;
    int rows;
    int cut;
    bit tail;

    rand_items = 0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // reset configuration: one column, one row
    offer_item(FUNC_LOAD, 16'h7FFF);
    offer_item(FUNC_MATRIX, 16'h7FFF);
    offer_item(FUNC_MATRIX, 16'h8000);
    offer_item(FUNC_LOAD, 16'h8000);
    offer_item(FUNC_MATRIX, 16'h8000);
    // minus one in the last place must floor to -1, not round to zero
    offer_item(FUNC_LOAD, 16'hFFFF);
    offer_item(FUNC_MATRIX, 16'h0001);
    offer_item(FUNC_LOAD, 16'h0001);
    offer_item(FUNC_MATRIX, 16'h0001);

    write_reg(REG_ROW_LENGTH, '0);
    write_reg(REG_ROW_COUNT, '0);
    offer_item(FUNC_LOAD, 16'h1234);
    offer_item(FUNC_MATRIX, 16'hFEDC);

    write_reg(REG_ROW_LENGTH, 16'hF803);
    write_reg(REG_ROW_COUNT, 16'd2);
    offer_item(FUNC_LOAD, 16'h8000);
    offer_item(FUNC_LOAD, 16'h7FFF);
    offer_item(FUNC_LOAD, 16'hAAAA);
    offer_item(FUNC_MATRIX, 16'h8000);
    offer_item(FUNC_MATRIX, 16'h8000);
    offer_item(FUNC_MATRIX, 16'h5555);
    offer_item(FUNC_MATRIX, 16'h7FFF);
    offer_item(FUNC_LOAD, 16'h0F0F);  // overwrite column 0 mid-row
    offer_item(FUNC_MATRIX, 16'h0000);
    offer_item(FUNC_MATRIX, 16'hFFFF);

    // a length above the maximum acts as the maximum: two columns must not end the row,
    // then shrink the length so the third column finishes it
    write_reg(REG_ROW_LENGTH, 16'h07FF);
    write_reg(REG_ROW_COUNT, 16'd1);
    stream_elems(2, 1'b0);
    write_reg(REG_ROW_LENGTH, 16'd3);
    stream_elems(1, 1'b0);

    while (rand_items < RANDOM_ITEMS) begin
      tail      = (rand_items >= RANDOM_ITEMS - TAIL_ITEMS);
      pace_src  = !tail && ($urandom_range(0, 9) < 7);
      pace_sink = !tail && ($urandom_range(0, 9) < 7);
      style     = $urandom_range(0, 9);
      pick      = $urandom_range(0, 19);
      if (pick < 14) cols = $urandom_range(1, 8);
      else if (pick < 19) cols = $urandom_range(9, 40);
      else cols = $urandom_range(41, 160);
      rows = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 25) : $urandom_range(1, 6);
      if (n_shapes == HOLD_SHAPE) begin
        cols  = 1;
        rows  = 60;
        style = 9;
      end
      start = n_loads + n_elems;

      write_reg(REG_ROW_LENGTH, encode_len(cols));
      write_reg(REG_ROW_COUNT, (style == 0) ? 16'hFFFF : encode_count(rows));
      load_vector();
      if (n_shapes == HOLD_SHAPE) hold_sink = 1'b1;

      case (style)
        0: begin
          // open-ended product: lower the count to the current row or below to end it
          stream_elems(rows * cols, 1'b1);
          write_reg(REG_ROW_COUNT, CFG_DATA_W'($urandom_range(0, rows)));
          stream_elems(cols, 1'b1);
        end
        1: begin
          // shrink the row length part way through the final row
          stream_elems((rows - 1) * cols, 1'b1);
          if (cols > 1) begin
            cut = $urandom_range(1, cols - 1);
            stream_elems(cut, 1'b1);
            write_reg(REG_ROW_LENGTH, encode_len($urandom_range(1, cut)));
            stream_elems(1, 1'b0);
          end else begin
            stream_elems(cols, 1'b1);
          end
        end
        2: stream_elems($urandom_range(1, rows * cols), 1'b1);  // abandon part way
        default: stream_elems(rows * cols, 1'b1);
      endcase

      rand_items += n_loads + n_elems - start;
      n_shapes++;
    end

    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d vector loads and %0d matrix elements over %0d random shapes",
             n_loads, n_elems, n_shapes);
    $display("plus directed corner rows; %0d row sums compared with %0d failures",
             rows_checked, fail_count);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
